@@ rtl/core/page_table_map_writer_assert.svh @@
// Assertion macros shared by the page table map writer RTL.
`ifndef PAGE_TABLE_MAP_WRITER_ASSERT_SVH
`define PAGE_TABLE_MAP_WRITER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PTMW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PTMW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ptmw_pkg.sv @@
// Shared constants, types and address helpers for the page table map writer.
package ptmw_pkg;

    localparam int POOL_TABLES       = 64;
    localparam int FIRST_LEVEL_SLOTS = 4096;

    // Slot map entry: 0 means no table, else pool index plus one.
    localparam int ENTRY_W = $clog2(POOL_TABLES + 1);
    localparam int SLOT_W  = $clog2(FIRST_LEVEL_SLOTS);

    localparam int BASE_W  = 18;
    localparam int VPAGE_W = 20;
    localparam int PFRAME_W = 20;
    localparam int FLAGS_W = 12;
    localparam int L2IDX_W = 8;
    localparam int ADDR_W  = 32;

    localparam logic [ADDR_W-1:0] POOL_OFFSET   = 32'h0000_4000;
    localparam logic [ADDR_W-1:0] TABLE_DESC_ID = 32'h0000_0001;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [SLOT_W-1:0]  t_slot;

    // Write request into the slot map memory
    typedef struct packed {
        logic   en;
        t_slot  addr;
        t_entry data;
    } t_slot_wr;

    // Byte address of a first-level table base
    function automatic logic [ADDR_W-1:0] l1_base(input logic [BASE_W-1:0] base);
        return {base, 14'b0};
    endfunction

    // Byte address of one 1 KB second-level table in the pool
    function automatic logic [ADDR_W-1:0] pool_addr(input logic [BASE_W-1:0] base,
                                                    input t_entry idx);
        logic [ADDR_W-1:0] idx_off;
        idx_off = {{(ADDR_W - ENTRY_W - 10){1'b0}}, idx, 10'b0};
        return l1_base(base) + POOL_OFFSET + idx_off;
    endfunction

endpackage

@@ rtl/core/ptmw_slot_mem.sv @@
// First-level slot map memory: one write port, one registered read port.
module ptmw_slot_mem (
    input  logic              i_clk,
    input  ptmw_pkg::t_slot_wr i_wr,
    input  logic              i_rd_en,
    input  ptmw_pkg::t_slot   i_rd_addr,
    output ptmw_pkg::t_entry  o_rd_data
);

    ptmw_pkg::t_entry r_mem [ptmw_pkg::FIRST_LEVEL_SLOTS];
    ptmw_pkg::t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/page_table_map_writer.sv @@
// Top level: turns map requests into first- and second-level descriptor writes.
// Flow: a start transfer issues the registered slot map read, S_LOOK checks the
// entry and registers the first result; a new table adds S_L2 for the small-page
// write. A new request is taken only in S_IDLE, while busy is low.
// Reset: synchronous; then busy stays high for a pass that clears every slot map
// entry. The receiver cannot stall: each result is shown for one cycle only.
`include "page_table_map_writer_assert.svh"

module page_table_map_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_wr_en,
    input  logic [17:0] i_table_base_16k,
    input  logic [19:0] i_virt_page,
    input  logic [19:0] i_phys_frame,
    input  logic [11:0] i_page_flags,
    output logic        o_strobe,
    output logic [31:0] o_write_address,
    output logic [31:0] o_write_data,
    output logic        o_status,
    output logic        o_last
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_L2
    } t_state;

    t_state r_state, n_state;

    logic [ptmw_pkg::BASE_W-1:0]   r_base;
    ptmw_pkg::t_entry              r_tables_used, n_tables_used;
    ptmw_pkg::t_slot               r_clr_idx, n_clr_idx;
    ptmw_pkg::t_slot               r_slot, n_slot;
    logic [ptmw_pkg::L2IDX_W-1:0]  r_l2idx, n_l2idx;
    logic [ptmw_pkg::ADDR_W-1:0]   r_page_desc, n_page_desc;
    logic [ptmw_pkg::ADDR_W-1:0]   r_tbl, n_tbl;

    logic                          r_strobe, n_strobe;
    logic [ptmw_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic [ptmw_pkg::ADDR_W-1:0]   r_data, n_data;
    logic                          r_status, n_status;
    logic                          r_last, n_last;

    logic                          accept;
    ptmw_pkg::t_slot_wr            slot_wr;
    ptmw_pkg::t_entry              rd_entry;
    logic [ptmw_pkg::ADDR_W-1:0]   tbl_found;
    logic [ptmw_pkg::ADDR_W-1:0]   tbl_new;
    logic [ptmw_pkg::ADDR_W-1:0]   l1_addr;
    logic [ptmw_pkg::ADDR_W-1:0]   l2_off;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    ptmw_slot_mem u_slot_mem (
        .i_clk     (i_clk),
        .i_wr      (slot_wr),
        .i_rd_en   (accept),
        .i_rd_addr (i_virt_page[19:8]),
        .o_rd_data (rd_entry)
    );

    // Address candidates for the looked-up request
    assign tbl_found = ptmw_pkg::pool_addr(r_base, rd_entry - ptmw_pkg::ENTRY_W'(1));
    assign tbl_new   = ptmw_pkg::pool_addr(r_base, r_tables_used);
    assign l1_addr   = ptmw_pkg::l1_base(r_base)
                     + {{(ptmw_pkg::ADDR_W - ptmw_pkg::SLOT_W - 2){1'b0}}, r_slot, 2'b0};
    assign l2_off    = {{(ptmw_pkg::ADDR_W - ptmw_pkg::L2IDX_W - 2){1'b0}}, r_l2idx, 2'b0};

    // Next state, slot map writes and result words
    always_comb begin
        n_state       = r_state;
        n_tables_used = r_tables_used;
        n_clr_idx     = r_clr_idx;
        n_slot        = r_slot;
        n_l2idx       = r_l2idx;
        n_page_desc   = r_page_desc;
        n_tbl         = r_tbl;
        n_strobe      = 1'b0;
        n_addr        = r_addr;
        n_data        = r_data;
        n_status      = ptmw_pkg::STATUS_OK;
        n_last        = 1'b0;
        slot_wr.en    = 1'b0;
        slot_wr.addr  = r_slot;
        slot_wr.data  = r_tables_used + ptmw_pkg::ENTRY_W'(1);

        case (r_state)
            S_CLEAR: begin
                // sweep the slot map to "no table"
                slot_wr.en   = 1'b1;
                slot_wr.addr = r_clr_idx;
                slot_wr.data = '0;
                n_clr_idx    = r_clr_idx + ptmw_pkg::SLOT_W'(1);
                if (r_clr_idx == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // capture the request while the slot map read is issued
                if (start) begin
                    n_slot      = i_virt_page[19:8];
                    n_l2idx     = i_virt_page[7:0];
                    n_page_desc = {i_phys_frame, i_page_flags};
                    n_state     = S_LOOK;
                end
            end
            S_LOOK: begin
                n_strobe = 1'b1;
                if (rd_entry != '0) begin
                    // slot already has a table: one small-page write
                    n_addr  = tbl_found + l2_off;
                    n_data  = r_page_desc;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_tables_used >= ptmw_pkg::ENTRY_W'(ptmw_pkg::POOL_TABLES)) begin
                    // pool exhausted: report full, change nothing
                    n_addr   = '0;
                    n_data   = '0;
                    n_status = ptmw_pkg::STATUS_FULL;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    // take the next pool table and write its first-level descriptor
                    slot_wr.en    = 1'b1;
                    n_tables_used = r_tables_used + ptmw_pkg::ENTRY_W'(1);
                    n_tbl         = tbl_new;
                    n_addr        = l1_addr;
                    n_data        = tbl_new | ptmw_pkg::TABLE_DESC_ID;
                    n_state       = S_L2;
                end
            end
            S_L2: begin
                // small-page write into the new table
                n_strobe = 1'b1;
                n_addr   = r_tbl + l2_off;
                n_data   = r_page_desc;
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, configuration and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_tables_used <= '0;
            r_clr_idx     <= '0;
            r_base        <= '0;
            r_strobe      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_tables_used <= n_tables_used;
            r_clr_idx     <= n_clr_idx;
            r_strobe      <= n_strobe;
            if (i_cfg_wr_en) begin
                r_base <= i_table_base_16k;
            end
        end
        r_slot      <= n_slot;
        r_l2idx     <= n_l2idx;
        r_page_desc <= n_page_desc;
        r_tbl       <= n_tbl;
        r_addr      <= n_addr;
        r_data      <= n_data;
        r_status    <= n_status;
        r_last      <= n_last;
    end

    assign o_strobe        = r_strobe;
    assign o_write_address = r_addr;
    assign o_write_data    = r_data;
    assign o_status        = r_status;
    assign o_last          = r_last;

    `PTMW_ASSERT_IMP(a_full_is_empty_last, o_strobe && o_status, o_last && (o_write_address == '0) && (o_write_data == '0), "full status must be a zero final result")
    `PTMW_ASSERT_IMP(a_pool_bound, 1'b1, r_tables_used <= ptmw_pkg::ENTRY_W'(ptmw_pkg::POOL_TABLES), "pool table count overran the pool")
    `PTMW_ASSERT_NXT(a_l1_then_l2, o_strobe && !o_last, o_strobe && o_last && !o_status, "first-level write must be followed by the small-page write")
    `PTMW_ASSERT_NXT(a_accept_no_result, accept, !o_strobe, "result strobed in the cycle after a start transfer")
    `PTMW_ASSERT_IMP(a_clear_quiet, r_state == S_CLEAR, !o_strobe && busy, "activity during the slot map clearing pass")

endmodule
